// ----- src/dte_pkg.sv -----
// Shared types and constants for the decision-tree evaluation core.
// Holds the input and result item structs, node record, command and code constants.
// No dependencies.
package dte_pkg;

    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 8;
    localparam int AXIS_W     = 4;
    localparam int STEP_OUT_W = 9;
    localparam int FC_W       = 5;
    localparam int ERR_W      = 2;
    localparam int KIND_W     = 2;

    localparam logic [FC_W-1:0] FC_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_NODE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FEAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVAL = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_STEPS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_AXIS  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [IDX_W-1:0]          node_index;
        logic                      node_is_leaf;
        logic [AXIS_W-1:0]         split_axis;
        logic signed [VALUE_W-1:0] split_threshold;
        logic [IDX_W-1:0]          left_child;
        logic [IDX_W-1:0]          right_child;
        logic signed [VALUE_W-1:0] leaf_output;
        logic [AXIS_W-1:0]         feature_slot;
        logic signed [VALUE_W-1:0] feature_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] prediction;
        logic [IDX_W-1:0]          leaf_reached;
        logic [STEP_OUT_W-1:0]     steps_taken;
        logic [ERR_W-1:0]          walk_error;
    } t_out_item;

    // One node table entry: 53 bits.
    typedef struct packed {
        logic                      is_leaf;
        logic [AXIS_W-1:0]         axis;
        logic signed [VALUE_W-1:0] threshold;
        logic [IDX_W-1:0]          left;
        logic [IDX_W-1:0]          right;
    } t_node;

    typedef enum logic [1:0] {
        OP_NODE,
        OP_FEAT,
        OP_EVAL
    } t_op;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_cmd;

endpackage

// ----- src/dte_front.sv -----
// Front stage of the decision-tree evaluation core: accepts input items,
// decodes the kind, drops items that change nothing and registers a command.
// Depends on dte_pkg.
module dte_front #(
    parameter int NODES = 256,
    parameter int DIMS  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  dte_pkg::t_in_item i_in_item,
    output logic            o_in_stall,
    input  logic            i_q_full,
    output logic            o_q_push,
    output dte_pkg::t_cmd   o_q_cmd
);
    import dte_pkg::*;

    localparam int MEM_DEPTH  = (NODES < 256) ? NODES : 256;
    localparam int FEAT_DEPTH = (DIMS < 16) ? DIMS : 16;

    logic  r_valid;
    t_cmd  r_cmd;
    logic  accept;
    logic  keep;
    t_op   op;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_cmd    = r_cmd;

    // Classify: drop unused kinds and writes to slots beyond the stores.
    always_comb begin
        keep = 1'b0;
        op   = OP_EVAL;
        unique case (i_in_item.kind)
            KIND_NODE: begin
                op   = OP_NODE;
                keep = ({1'b0, i_in_item.node_index} < 9'(MEM_DEPTH));
            end
            KIND_FEAT: begin
                op   = OP_FEAT;
                keep = ({1'b0, i_in_item.feature_slot} < 5'(FEAT_DEPTH));
            end
            KIND_EVAL: begin
                op   = OP_EVAL;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op   <= op;
            r_cmd.item <= i_in_item;
        end
    end

endmodule

// ----- src/dte_cmd_fifo.sv -----
// Two-entry command queue between the front and back stages of the
// decision-tree evaluation core. Depends on dte_pkg.
module dte_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dte_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output dte_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import dte_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            priority if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- src/dte_back.sv -----
// Back stage of the decision-tree evaluation core: node and feature stores,
// the walk sequencer and the result register. Depends on dte_pkg.
module dte_back #(
    parameter int NODES = 256,
    parameter int DIMS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dte_pkg::FC_W-1:0]    i_cfg_wdata,
    input  dte_pkg::t_cmd               i_q_cmd,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    output dte_pkg::t_out_item          o_out_item,
    input  logic                        i_out_stall
);
    import dte_pkg::*;

    localparam int MEM_DEPTH  = (NODES < 256) ? NODES : 256;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int FEAT_DEPTH = (DIMS < 16) ? DIMS : 16;
    localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int STEP_W     = $clog2(NODES + 1);
    localparam int DIMS_CAP   = (DIMS < 31) ? DIMS : 31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_CMP
    } t_state;

    t_node                     split_mem [MEM_DEPTH];
    logic signed [VALUE_W-1:0] leaf_mem  [MEM_DEPTH];
    logic signed [VALUE_W-1:0] feat_mem  [FEAT_DEPTH];

    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_cur, n_cur;
    logic [STEP_W-1:0]         r_steps, n_steps;
    logic signed [VALUE_W-1:0] r_thr, n_thr;
    logic [IDX_W-1:0]          r_left, n_left;
    logic [IDX_W-1:0]          r_right, n_right;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_item;
    logic [FC_W-1:0]           r_fc;

    t_node                     r_node_rd;
    logic signed [VALUE_W-1:0] r_leaf_rd;
    logic signed [VALUE_W-1:0] r_feat_rd;

    t_node                     node_cur;
    logic                      cur_oor;
    logic                      out_free;
    logic                      node_we;
    logic                      feat_we;
    logic                      fin;
    t_out_item                 fin_item;
    logic [FEAT_AW-1:0]        feat_rd_addr;
    logic [FC_W-1:0]           limit;
    logic                      axis_bad;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    // A child beyond the table reads as an all-zero split node.
    assign cur_oor  = ({1'b0, r_cur} >= 9'(MEM_DEPTH));
    assign node_cur = cur_oor ? '0 : r_node_rd;
    assign limit    = (r_fc > 5'(DIMS_CAP)) ? 5'(DIMS_CAP) : r_fc;
    assign axis_bad = ({1'b0, node_cur.axis} >= limit);
    assign feat_rd_addr = node_cur.axis[FEAT_AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_thr       = r_thr;
        n_left      = r_left;
        n_right     = r_right;
        n_out_valid = r_out_valid && i_out_stall;
        o_q_pop     = 1'b0;
        node_we     = 1'b0;
        feat_we     = 1'b0;
        fin         = 1'b0;
        fin_item.prediction   = '0;
        fin_item.leaf_reached = r_cur;
        fin_item.steps_taken  = STEP_OUT_W'(r_steps);
        fin_item.walk_error   = ERR_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        OP_NODE: node_we = 1'b1;
                        OP_FEAT: feat_we = 1'b1;
                        OP_EVAL: begin
                            n_cur   = '0;
                            n_steps = '0;
                            n_state = S_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP: begin
                priority if (node_cur.is_leaf) begin
                    // hold until the result register is free
                    if (out_free) begin
                        fin                 = 1'b1;
                        fin_item.prediction = r_leaf_rd;
                        n_state             = S_IDLE;
                    end
                end else if (r_steps >= STEP_W'(NODES)) begin
                    if (out_free) begin
                        fin                 = 1'b1;
                        fin_item.walk_error = ERR_STEPS;
                        n_state             = S_IDLE;
                    end
                end else if (axis_bad) begin
                    if (out_free) begin
                        fin                 = 1'b1;
                        fin_item.walk_error = ERR_AXIS;
                        n_state             = S_IDLE;
                    end
                end else begin
                    n_thr   = node_cur.threshold;
                    n_left  = node_cur.left;
                    n_right = node_cur.right;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_cur   = (r_feat_rd <= r_thr) ? r_left : r_right;
                n_steps = r_steps + STEP_W'(1);
                n_state = S_STEP;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fc        <= FC_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fc <= i_cfg_wdata;
            end
        end
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_thr   <= n_thr;
        r_left  <= n_left;
        r_right <= n_right;
        if (fin) begin
            r_out_item <= fin_item;
        end
    end

    // Node stores: written by node commands, read at the next walk position.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            split_mem[i_q_cmd.item.node_index[MEM_AW-1:0]] <= '{
                is_leaf:   i_q_cmd.item.node_is_leaf,
                axis:      i_q_cmd.item.split_axis,
                threshold: i_q_cmd.item.split_threshold,
                left:      i_q_cmd.item.left_child,
                right:     i_q_cmd.item.right_child
            };
            leaf_mem[i_q_cmd.item.node_index[MEM_AW-1:0]] <= i_q_cmd.item.leaf_output;
        end
        r_node_rd <= split_mem[n_cur[MEM_AW-1:0]];
        r_leaf_rd <= leaf_mem[n_cur[MEM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (feat_we) begin
            feat_mem[i_q_cmd.item.feature_slot[FEAT_AW-1:0]] <= i_q_cmd.item.feature_value;
        end
        r_feat_rd <= feat_mem[feat_rd_addr];
    end

endmodule

// ----- src/decision_tree_eval_core.sv -----
// Decision-tree evaluation core: node table and feature vector loaded by write
// items, tree walk on evaluate items. An accepted item passes the input register
// and a two-entry command queue before the back stage executes it. Node and
// feature writes give no result. During an evaluate item every level of the
// walk needs a registered node-table read followed by a registered feature
// read, and the walk holds the back stage until its result enters the output
// register. Errors (walk longer than NODES splits, or a split axis at or above
// the smaller of feature_count and DIMS) end the walk with prediction 0 and the
// stopping node's slot. Node table and features are undefined until written.
// Depends on dte_pkg, dte_front, dte_cmd_fifo and dte_back.
module decision_tree_eval_core #(
    parameter int NODES = 256,
    parameter int DIMS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [dte_pkg::FC_W-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    input  dte_pkg::t_in_item        i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output dte_pkg::t_out_item       o_out_item,
    input  logic                     i_out_stall
);
    import dte_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    dte_front #(
        .NODES (NODES),
        .DIMS  (DIMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    dte_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dte_back #(
        .NODES (NODES),
        .DIMS  (DIMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_cmd     (q_out_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
